>>> sv/aac_pkg.sv
package aac_pkg;

	localparam int unsigned MAX_PIXELS_DEF = 16777216;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned SUM_W = 32;
	localparam int unsigned STEP_W = $clog2(SUM_W);
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SNAP_HIGH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_LOW = CFG_IDX_W'(1);

	localparam logic [PIX_W-1:0] SNAP_HIGH_RST = PIX_W'(200);
	localparam logic [PIX_W-1:0] SNAP_LOW_RST = PIX_W'(100);
	localparam logic [PIX_W-1:0] PIX_MAX = '1;
	localparam logic [PIX_W-1:0] PIX_ZERO = '0;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic acc;
		logic load_div;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

>>> sv/aac_ctrl.sv
module aac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             frame_end,
	input  aac_pkg::stat_t   stat,
	output aac_pkg::cmd_t    cmd
);

	aac_pkg::state_t state_q;
	aac_pkg::state_t state_d;
	logic [aac_pkg::STEP_W-1:0] step_q;
	logic [aac_pkg::STEP_W-1:0] step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aac_pkg::ST_ACC;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			aac_pkg::ST_ACC: begin
				in_ready = 1'b1;
				cmd.acc = in_valid;
				if (in_valid && frame_end) begin
					state_d = aac_pkg::ST_START;
				end
			end
			aac_pkg::ST_START: begin
				cmd.load_div = 1'b1;
				step_d = '0;
				state_d = aac_pkg::ST_DIV;
			end
			aac_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == aac_pkg::STEP_W'(aac_pkg::SUM_W - 1)) begin
					state_d = aac_pkg::ST_FIN;
				end
			end
			aac_pkg::ST_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = aac_pkg::ST_ACC;
				end
			end
			default: begin
				state_d = aac_pkg::ST_ACC;
			end
		endcase
	end

endmodule

>>> sv/aac_div.sv
module aac_div #(
	parameter int unsigned CNT_W = 25
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic                     step,
	input  logic [aac_pkg::SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic [aac_pkg::SUM_W-1:0] quotient
);

	logic [CNT_W-1:0] rem_q;
	logic [aac_pkg::SUM_W-1:0] dvd_q;
	logic [aac_pkg::SUM_W-1:0] quo_q;
	logic [CNT_W:0] trial;
	logic ge;

	assign trial = {rem_q, dvd_q[aac_pkg::SUM_W-1]};
	assign ge = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[aac_pkg::SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[aac_pkg::SUM_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

>>> sv/aac_dp.sv
module aac_dp #(
	parameter int unsigned MAX_PIXELS = aac_pkg::MAX_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aac_pkg::cmd_t                 cmd,
	output aac_pkg::stat_t                stat,
	input  logic [aac_pkg::PIX_W-1:0]     red,
	input  logic [aac_pkg::PIX_W-1:0]     green,
	input  logic [aac_pkg::PIX_W-1:0]     blue,
	input  logic                          cfg_valid,
	input  logic [aac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aac_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [aac_pkg::PIX_W-1:0]     avg_red,
	output logic [aac_pkg::PIX_W-1:0]     avg_green,
	output logic [aac_pkg::PIX_W-1:0]     avg_blue
);

	localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 2);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PIXELS + 1);
	localparam int unsigned SW = aac_pkg::SUM_W;
	localparam int unsigned PW = aac_pkg::PIX_W;

	logic [SW-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] divisor_q;
	logic [PW-1:0] snap_high_q, snap_low_q;
	logic out_valid_q;
	logic [PW-1:0] avg_r_q, avg_g_q, avg_b_q;
	logic colored;
	logic [SW-1:0] quo_r, quo_g, quo_b;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
		input logic [PW-1:0] v);
		logic [SW:0] s;
		s = {1'b0, acc} + (SW + 1)'(v);
		return s[SW] ? '1 : s[SW-1:0];
	endfunction

	function automatic logic [PW-1:0] snap(input logic [SW-1:0] q,
		input logic [PW-1:0] hi, input logic [PW-1:0] lo);
		logic [PW-1:0] a;
		a = (q[SW-1:PW] != '0) ? aac_pkg::PIX_MAX : q[PW-1:0];
		if (a > hi) begin
			return aac_pkg::PIX_MAX;
		end else if (a < lo) begin
			return aac_pkg::PIX_ZERO;
		end
		return a;
	endfunction

	assign colored = !((red == green) && (green == blue));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q <= CNT_W'(1);
		end else if (cmd.load_div) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q <= CNT_W'(1);
		end else if (cmd.acc && colored) begin
			sum_r_q <= sat_add(sum_r_q, red);
			sum_g_q <= sat_add(sum_g_q, green);
			sum_b_q <= sat_add(sum_b_q, blue);
			if (cnt_q < CNT_LIMIT) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			divisor_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_high_q <= aac_pkg::SNAP_HIGH_RST;
			snap_low_q <= aac_pkg::SNAP_LOW_RST;
		end else if (cfg_valid) begin
			if (cfg_index == aac_pkg::REG_SNAP_HIGH) begin
				snap_high_q <= cfg_data[PW-1:0];
			end else if (cfg_index == aac_pkg::REG_SNAP_LOW) begin
				snap_low_q <= cfg_data[PW-1:0];
			end
		end
	end

	aac_div #(.CNT_W(CNT_W)) u_div_r (
		.clk(clk), .load(cmd.load_div), .step(cmd.step),
		.dividend(sum_r_q), .divisor(divisor_q), .quotient(quo_r)
	);

	aac_div #(.CNT_W(CNT_W)) u_div_g (
		.clk(clk), .load(cmd.load_div), .step(cmd.step),
		.dividend(sum_g_q), .divisor(divisor_q), .quotient(quo_g)
	);

	aac_div #(.CNT_W(CNT_W)) u_div_b (
		.clk(clk), .load(cmd.load_div), .step(cmd.step),
		.dividend(sum_b_q), .divisor(divisor_q), .quotient(quo_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_r_q <= snap(quo_r, snap_high_q, snap_low_q);
			avg_g_q <= snap(quo_g, snap_high_q, snap_low_q);
			avg_b_q <= snap(quo_b, snap_high_q, snap_low_q);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign avg_red = avg_r_q;
	assign avg_green = avg_g_q;
	assign avg_blue = avg_b_q;

endmodule

>>> sv/ambient_average_color.sv
// Pixels transfer at one per cycle while a frame accumulates.
// The last pixel of a frame starts a bit-serial division (ST_START, then
// ST_DIV, then ST_FIN), and input is held off until the result is loaded
// into the output register, once it has drained, and out_valid rises.
// Reset clears sums and output valid, sets the count to 1 and the snap
// thresholds to 200 and 100.
module ambient_average_color #(
	parameter int unsigned MAX_PIXELS = aac_pkg::MAX_PIXELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [aac_pkg::PIX_W-1:0]      red,
	input  logic [aac_pkg::PIX_W-1:0]      green,
	input  logic [aac_pkg::PIX_W-1:0]      blue,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [aac_pkg::PIX_W-1:0]      avg_red,
	output logic [aac_pkg::PIX_W-1:0]      avg_green,
	output logic [aac_pkg::PIX_W-1:0]      avg_blue,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [aac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aac_pkg::CFG_DATA_W-1:0] cfg_data
);

	aac_pkg::cmd_t cmd;
	aac_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	aac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_end(frame_end),
		.stat(stat),
		.cmd(cmd)
	);

	aac_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_red(avg_red),
		.avg_green(avg_green),
		.avg_blue(avg_blue)
	);

endmodule
